@@ design/rau_pkg.sv @@
// Shared constants and codes for the rational arithmetic unit.
package rau_pkg;

    // Default operand width and the fixed width of every numeric field.
    localparam int DEF_WIDTH = 32;
    localparam int FIELD_W   = 32;

    // Action codes.
    localparam logic [2:0] ACT_ADD = 3'd0;
    localparam logic [2:0] ACT_SUB = 3'd1;
    localparam logic [2:0] ACT_MUL = 3'd2;
    localparam logic [2:0] ACT_DIV = 3'd3;
    localparam logic [2:0] ACT_CMP = 3'd4;

    // Status codes.
    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_OVF  = 2'd1;
    localparam logic [1:0] ST_ZERO = 2'd2;

    // Compare order codes.
    localparam logic [1:0] ORD_LESS    = 2'd0;
    localparam logic [1:0] ORD_EQUAL   = 2'd1;
    localparam logic [1:0] ORD_GREATER = 2'd2;

endpackage

@@ design/rau_gcd.sv @@
// Iterative binary GCD of two nonzero unsigned values, one step per cycle.
module rau_gcd #(
    parameter int DW = 2 * rau_pkg::DEF_WIDTH
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    input  logic [DW-1:0] x,
    input  logic [DW-1:0] y,
    output logic          done,
    output logic [DW-1:0] g
);
    import rau_pkg::*;

    localparam int KW = $clog2(DW);

    logic [DW-1:0] u_reg, u_next;
    logic [DW-1:0] v_reg, v_next;
    logic [KW-1:0] k_reg, k_next;
    logic          busy_reg, busy_next;
    logic          done_reg, done_next;

    // One reduction step: finish when equal, strip common twos, strip single twos, or subtract.
    always_comb
    begin
        u_next    = u_reg;
        v_next    = v_reg;
        k_next    = k_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            u_next    = x;
            v_next    = y;
            k_next    = '0;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (u_reg == v_reg)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
            else if (!u_reg[0] && !v_reg[0])
            begin
                u_next = u_reg >> 1;
                v_next = v_reg >> 1;
                k_next = k_reg + KW'(1);
            end
            else if (!u_reg[0])
            begin
                u_next = u_reg >> 1;
            end
            else if (!v_reg[0])
            begin
                v_next = v_reg >> 1;
            end
            else if (u_reg > v_reg)
            begin
                u_next = u_reg - v_reg;
            end
            else
            begin
                v_next = v_reg - u_reg;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        u_reg <= u_next;
        v_reg <= v_next;
        k_reg <= k_next;
    end

    // The common power of two is restored on the way out.
    assign done = done_reg;
    assign g    = u_reg << k_reg;

endmodule

@@ design/rau_div.sv @@
// Restoring unsigned divider, one quotient bit per cycle.
module rau_div #(
    parameter int DW = 2 * rau_pkg::DEF_WIDTH
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    input  logic [DW-1:0] dividend,
    input  logic [DW-1:0] divisor,
    output logic          done,
    output logic [DW-1:0] quotient
);
    import rau_pkg::*;

    localparam int CW = $clog2(DW);

    logic [DW-1:0] rem_reg, rem_next;
    logic [DW-1:0] quo_reg, quo_next;
    logic [DW-1:0] dsr_reg, dsr_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic          busy_reg, busy_next;
    logic          done_reg, done_next;
    logic [DW:0]   trial;
    logic          fits;

    // Shift in the next dividend bit and try the subtraction.
    assign trial = {rem_reg, quo_reg[DW-1]};
    assign fits  = trial >= {1'b0, dsr_reg};

    always_comb
    begin
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        dsr_next  = dsr_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            rem_next  = '0;
            quo_next  = dividend;
            dsr_next  = divisor;
            cnt_next  = CW'(DW - 1);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (fits)
            begin
                rem_next = DW'(trial - {1'b0, dsr_reg});
            end
            else
            begin
                rem_next = trial[DW-1:0];
            end
            quo_next = {quo_reg[DW-2:0], fits};
            cnt_next = cnt_reg - CW'(1);
            if (cnt_reg == '0)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        dsr_reg <= dsr_next;
        cnt_reg <= cnt_next;
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

@@ design/rational_arith_unit_top.sv @@
// Rational arithmetic unit: one WIDTH x WIDTH multiplier, binary GCD, serial divider.
// A request runs through the multiply steps, a binary GCD loop and two divisions by the
// GCD; errors go straight to the output, and zero results and compares skip the GCD and
// the divisions. One request is in flight at a time: a new one is taken only once the
// sequencer is back in idle. Reset clears the sequencer and the output valid.
module rational_arith_unit_top #(
    parameter int WIDTH = rau_pkg::DEF_WIDTH
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    s_tvalid,
    output logic                    s_tready,
    input  logic [127:0]            s_tdata,  // a_num, a_den, b_num, b_den
    input  logic [2:0]              s_tuser,  // action
    output logic                    m_tvalid,
    input  logic                    m_tready,
    output logic [71:0]             m_tdata   // res_num, res_den, status, order, zero pad
);
    import rau_pkg::*;

    localparam int DW = 2 * WIDTH;
    localparam logic [DW-1:0] SBIT = DW'(1) << (WIDTH - 1);

    typedef enum logic [8:0] {
        S_IDLE = 9'b000000001,
        S_MUL1 = 9'b000000010,
        S_MUL2 = 9'b000000100,
        S_MUL3 = 9'b000001000,
        S_COMB = 9'b000010000,
        S_GCD  = 9'b000100000,
        S_DIVN = 9'b001000000,
        S_DIVD = 9'b010000000,
        S_DONE = 9'b100000000
    } state_t;

    state_t state_reg, state_next;

    // Captured operands in sign-magnitude form.
    logic [2:0]       act_reg, act_next;
    logic [WIDTH-1:0] am_reg, am_next, bm_reg, bm_next;
    logic [WIDTH-1:0] ad_reg, ad_next, bd_reg, bd_next;
    logic             as_reg, as_next, bs_reg, bs_next;

    // Products, working fraction and result fields.
    logic [DW-1:0]    p_reg, p_next, q_reg, q_next, d_reg, d_next;
    logic [DW-1:0]    nm_reg, nm_next, dn_reg, dn_next, g_reg, g_next;
    logic             neg_reg, neg_next;
    logic             arith_reg, arith_next;
    logic [1:0]       st_reg, st_next, ord_reg, ord_next;

    // Output register.
    logic             m_tvalid_reg, m_tvalid_next;
    logic [31:0]      rn_reg, rn_next, rd_reg, rd_next;
    logic [1:0]       ost_reg, ost_next, oord_reg, oord_next;

    // Input field views.
    logic [WIDTH-1:0] in_an, in_ad, in_bn, in_bd;
    logic             in_err;

    // Shared multiplier.
    logic [WIDTH-1:0] mul_a, mul_b;
    logic [DW-1:0]    mul_p;

    // Combine step.
    logic             qs;
    logic [DW-1:0]    sum_nm, sum_dn;
    logic             sum_neg;
    logic signed [DW:0] cmp_l, cmp_r;

    // Finish step.
    logic             ovf;
    logic [WIDTH:0]   rn_w;

    // Unit handshakes.
    logic             gcd_start, gcd_done, div_start, div_done;
    logic [DW-1:0]    gcd_g, div_dividend, div_divisor, div_q;

    assign in_an  = s_tdata[WIDTH-1:0];
    assign in_ad  = s_tdata[32 +: WIDTH];
    assign in_bn  = s_tdata[64 +: WIDTH];
    assign in_bd  = s_tdata[96 +: WIDTH];
    assign in_err = (s_tuser > ACT_CMP) || (in_ad == '0) || (in_bd == '0) ||
                    ((s_tuser == ACT_DIV) && (in_bn == '0));

    // Multiplier operands follow the sequencer step.
    always_comb
    begin
        mul_a = am_reg;
        mul_b = bd_reg;
        case (state_reg)
            S_MUL1:
            begin
                mul_a = am_reg;
                mul_b = (act_reg == ACT_MUL) ? bm_reg : bd_reg;
            end
            S_MUL2:
            begin
                mul_a = ad_reg;
                if (act_reg == ACT_MUL)
                begin
                    mul_b = bd_reg;
                end
                else
                begin
                    mul_b = bm_reg;
                end
            end
            S_MUL3:
            begin
                mul_a = ad_reg;
                mul_b = bd_reg;
            end
            default:
            begin
                mul_a = am_reg;
                mul_b = bd_reg;
            end
        endcase
    end
    assign mul_p = DW'(mul_a) * DW'(mul_b);

    // Signed sum of the two cross products for add and subtract; other actions pass p and q through.
    assign qs = (act_reg == ACT_SUB) ? !bs_reg : bs_reg;
    always_comb
    begin
        if (as_reg == qs)
        begin
            sum_nm  = p_reg + q_reg;
            sum_neg = as_reg;
        end
        else if (p_reg >= q_reg)
        begin
            sum_nm  = p_reg - q_reg;
            sum_neg = as_reg;
        end
        else
        begin
            sum_nm  = q_reg - p_reg;
            sum_neg = qs;
        end
        if ((act_reg == ACT_ADD) || (act_reg == ACT_SUB))
        begin
            sum_dn = d_reg;
        end
        else
        begin
            sum_nm  = p_reg;
            sum_dn  = q_reg;
            sum_neg = as_reg != bs_reg;
        end
    end

    // Exact compare of the two cross products.
    assign cmp_l = as_reg ? -$signed({1'b0, p_reg}) : $signed({1'b0, p_reg});
    assign cmp_r = bs_reg ? -$signed({1'b0, q_reg}) : $signed({1'b0, q_reg});

    // Range check of the reduced fraction.
    assign ovf  = (dn_reg[DW-1:WIDTH] != '0) ||
                  (neg_reg ? (nm_reg > SBIT) : (nm_reg >= SBIT));
    assign rn_w = neg_reg ? -{1'b0, nm_reg[WIDTH-1:0]} : {1'b0, nm_reg[WIDTH-1:0]};

    assign gcd_start    = (state_reg == S_COMB) && (act_reg != ACT_CMP) && (sum_nm != '0);
    assign div_start    = ((state_reg == S_GCD) && gcd_done) ||
                          ((state_reg == S_DIVN) && div_done);
    assign div_dividend = (state_reg == S_GCD) ? nm_reg : dn_reg;
    assign div_divisor  = (state_reg == S_GCD) ? gcd_g : g_reg;

    // Sequencer.
    always_comb
    begin
        state_next    = state_reg;
        act_next      = act_reg;
        am_next       = am_reg;
        bm_next       = bm_reg;
        ad_next       = ad_reg;
        bd_next       = bd_reg;
        as_next       = as_reg;
        bs_next       = bs_reg;
        p_next        = p_reg;
        q_next        = q_reg;
        d_next        = d_reg;
        nm_next       = nm_reg;
        dn_next       = dn_reg;
        g_next        = g_reg;
        neg_next      = neg_reg;
        arith_next    = arith_reg;
        st_next       = st_reg;
        ord_next      = ord_reg;
        m_tvalid_next = m_tvalid_reg && !m_tready;
        rn_next       = rn_reg;
        rd_next       = rd_reg;
        ost_next      = ost_reg;
        oord_next     = oord_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (s_tvalid)
                begin
                    act_next   = s_tuser;
                    as_next    = in_an[WIDTH-1];
                    bs_next    = in_bn[WIDTH-1];
                    am_next    = in_an[WIDTH-1] ? -in_an : in_an;
                    bm_next    = in_bn[WIDTH-1] ? -in_bn : in_bn;
                    ad_next    = in_ad;
                    bd_next    = in_bd;
                    arith_next = 1'b0;
                    st_next    = ST_OK;
                    ord_next   = ORD_LESS;
                    if (in_err)
                    begin
                        st_next    = ST_ZERO;
                        state_next = S_DONE;
                    end
                    else
                    begin
                        state_next = S_MUL1;
                    end
                end
            end
            S_MUL1:
            begin
                p_next     = mul_p;
                state_next = S_MUL2;
            end
            S_MUL2:
            begin
                q_next = mul_p;
                if ((act_reg == ACT_ADD) || (act_reg == ACT_SUB))
                begin
                    state_next = S_MUL3;
                end
                else
                begin
                    state_next = S_COMB;
                end
            end
            S_MUL3:
            begin
                d_next     = mul_p;
                state_next = S_COMB;
            end
            S_COMB:
            begin
                if (act_reg == ACT_CMP)
                begin
                    if (cmp_l < cmp_r)
                    begin
                        ord_next = ORD_LESS;
                    end
                    else if (cmp_l == cmp_r)
                    begin
                        ord_next = ORD_EQUAL;
                    end
                    else
                    begin
                        ord_next = ORD_GREATER;
                    end
                    state_next = S_DONE;
                end
                else if (sum_nm == '0)
                begin
                    // A zero numerator is always 0/1.
                    nm_next    = '0;
                    dn_next    = DW'(1);
                    neg_next   = 1'b0;
                    arith_next = 1'b1;
                    state_next = S_DONE;
                end
                else
                begin
                    nm_next    = sum_nm;
                    dn_next    = sum_dn;
                    neg_next   = sum_neg;
                    arith_next = 1'b1;
                    state_next = S_GCD;
                end
            end
            S_GCD:
            begin
                if (gcd_done)
                begin
                    g_next     = gcd_g;
                    state_next = S_DIVN;
                end
            end
            S_DIVN:
            begin
                if (div_done)
                begin
                    nm_next    = div_q;
                    state_next = S_DIVD;
                end
            end
            S_DIVD:
            begin
                if (div_done)
                begin
                    dn_next    = div_q;
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                // Load the output register once it is free.
                if (!m_tvalid_reg || m_tready)
                begin
                    m_tvalid_next = 1'b1;
                    rn_next       = '0;
                    rd_next       = '0;
                    ost_next      = st_reg;
                    oord_next     = ord_reg;
                    if (arith_reg)
                    begin
                        if (ovf)
                        begin
                            ost_next = ST_OVF;
                        end
                        else
                        begin
                            rn_next = 32'($signed(rn_w));
                            rd_next = 32'(dn_reg[WIDTH-1:0]);
                        end
                    end
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        act_reg   <= act_next;
        am_reg    <= am_next;
        bm_reg    <= bm_next;
        ad_reg    <= ad_next;
        bd_reg    <= bd_next;
        as_reg    <= as_next;
        bs_reg    <= bs_next;
        p_reg     <= p_next;
        q_reg     <= q_next;
        d_reg     <= d_next;
        nm_reg    <= nm_next;
        dn_reg    <= dn_next;
        g_reg     <= g_next;
        neg_reg   <= neg_next;
        arith_reg <= arith_next;
        st_reg    <= st_next;
        ord_reg   <= ord_next;
        rn_reg    <= rn_next;
        rd_reg    <= rd_next;
        ost_reg   <= ost_next;
        oord_reg  <= oord_next;
    end

    rau_gcd #(
        .DW (DW)
    ) u_gcd (
        .clk   (clk),
        .rst_n (rst_n),
        .start (gcd_start),
        .x     (sum_nm),
        .y     (sum_dn),
        .done  (gcd_done),
        .g     (gcd_g)
    );

    rau_div #(
        .DW (DW)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .done     (div_done),
        .quotient (div_q)
    );

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {4'b0000, oord_reg, ost_reg, rd_reg, rn_reg};

    // A new request is taken only while the sequencer is idle.
    a_ready_idle: assert property (@(posedge clk) disable iff (!rst_n)
        s_tready |-> (state_reg == S_IDLE))
        else $error("request accepted while busy");

    // An overflow or error result carries a zero fraction.
    a_fault_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && (ost_reg != ST_OK)) |-> ((rn_reg == '0) && (rd_reg == '0)))
        else $error("faulted result with nonzero fraction");

    // A good arithmetic result has a nonzero denominator.
    a_den_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == S_DONE) && arith_reg && !ovf) |-> (dn_reg != '0))
        else $error("reduced denominator is zero");

endmodule
